[design/bitmap_first_fit_region_allocator_assert.svh]
// assertion macros for the bitmap first-fit region allocator
// expects clk and rst_n in the scope where a macro is used
`ifndef BITMAP_FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define BFFRA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bffra assertion failed");
`define BFFRA_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bffra forbidden condition seen");
`else
`define BFFRA_ASSERT(lbl, prop)
`define BFFRA_ASSERT_NEVER(lbl, cond)
`endif
`endif

[design/bffra_pkg.sv]
// shared widths, codes and interface structs of the bitmap allocator
// no dependencies
`timescale 1ns / 1ps

package bffra_pkg;

    localparam int MODE_W       = 2;
    localparam int BYTES_W      = 24;
    localparam int IDX_W        = 10;
    localparam int STATUS_W     = 2;
    localparam int SLOT_W       = 10;
    localparam int BB_W         = 17;
    localparam int NUM_W        = 25;
    localparam int LEN_W        = 11;
    localparam int REGN_W       = 3;
    localparam int REGION_SLOTS = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 17;
    // four regions of at most 2047 blocks each end below 8192
    localparam int SPAN_W       = 13;
    localparam int DIV_CNT_W    = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_FIND      = 2'd0,
        MODE_MARK_USED = 2'd1,
        MODE_MARK_FREE = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 2'd0,
        ST_NO_ROOM   = 2'd1,
        ST_MARK_DONE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_BYTES = 3'd0,
        CFG_REGIONS     = 3'd1,
        CFG_REGION0     = 3'd2,
        CFG_REGION1     = 3'd3,
        CFG_REGION2     = 3'd4,
        CFG_REGION3     = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [BB_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  need;
        logic [REGN_W-1:0] nreg;
    } scan_req_t;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [SLOT_W-1:0] slot;
    } scan_rsp_t;

endpackage

[design/bffra_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bffra_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/bffra_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on bffra_pkg
`timescale 1ns / 1ps

module bffra_div (
    input  logic                clk,
    input  logic                rst_n,
    input  bffra_pkg::div_req_t req,
    output bffra_pkg::div_rsp_t rsp
);

    localparam int NW = bffra_pkg::NUM_W;
    localparam int DW = bffra_pkg::BB_W;
    localparam int CW = bffra_pkg::DIV_CNT_W;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [DW:0]   rem_sh;
    logic          ge;
    logic [DW-1:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[NW-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !req.start && (cnt_reg == CW'(NW - 1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // quotient bits shift in from the right as the dividend shifts out
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.dividend;
            den_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;

endmodule

[design/bffra_scan.sv]
// serial first-fit scan over the occupancy map, one block per cycle while not moving to the next region
// depends on bffra_pkg; reads the map ram through a registered read port
`timescale 1ns / 1ps

module bffra_scan #(
    parameter int TOTAL_BLOCKS = 1024,
    parameter int MAP_AW       = 10,
    parameter int POS_W        = 13
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  bffra_pkg::scan_req_t                                  req,
    input  logic [bffra_pkg::REGION_SLOTS-1:0][bffra_pkg::LEN_W-1:0] region_len,
    output logic [MAP_AW-1:0]                                     rd_addr,
    input  logic                                                  rd_data,
    output bffra_pkg::scan_rsp_t                                  rsp
);

    localparam int LW = bffra_pkg::LEN_W;
    localparam int NW = bffra_pkg::NUM_W;
    localparam int RW = bffra_pkg::REGN_W;
    localparam int SW = bffra_pkg::SLOT_W;

    logic          busy_reg;
    logic [NW-1:0] need_reg;
    logic [RW-1:0] nreg_reg;
    logic [RW-1:0] r_reg;
    logic [LW-1:0] i_reg;
    logic [POS_W-1:0] base_reg;
    logic [LW-1:0] run_reg;
    // read-data stage: the block whose map bit arrives this cycle
    logic          ev_valid_reg;
    logic          ev_first_reg;
    logic          ev_oob_reg;
    logic [POS_W-1:0] ev_pos_reg;
    logic          done_reg;
    logic          found_reg;
    logic [SW-1:0] slot_reg;

    logic [LW-1:0]    len_cur;
    logic             iss_end;
    logic             skip;
    logic [POS_W-1:0] pos_cur;
    logic             blk_busy;
    logic [LW-1:0]    run_base;
    logic [LW-1:0]    run_inc;
    logic             hit;
    logic             miss;
    logic [POS_W-1:0] slot_pos;

    always_comb
    begin
        len_cur  = region_len[r_reg[1:0]];
        iss_end  = (r_reg == nreg_reg);
        skip     = (need_reg > NW'(len_cur)) || (i_reg == len_cur);
        pos_cur  = base_reg + POS_W'(i_reg);
        rd_addr  = pos_cur[MAP_AW-1:0];
        blk_busy = ev_oob_reg | rd_data;
        run_base = ev_first_reg ? '0 : run_reg;
        run_inc  = run_base + LW'(1);
        hit      = ev_valid_reg && !blk_busy && (run_inc == need_reg[LW-1:0]);
        miss     = iss_end && !ev_valid_reg;
        slot_pos = ev_pos_reg + POS_W'(1) - POS_W'(need_reg[LW-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            ev_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
            slot_reg     <= '0;
            need_reg     <= '0;
            nreg_reg     <= '0;
            r_reg        <= '0;
            i_reg        <= '0;
            base_reg     <= '0;
            run_reg      <= '0;
            ev_first_reg <= 1'b0;
            ev_oob_reg   <= 1'b0;
            ev_pos_reg   <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !req.start && (hit || miss);
            if (req.start)
            begin
                busy_reg     <= 1'b1;
                need_reg     <= req.need;
                nreg_reg     <= req.nreg;
                r_reg        <= '0;
                i_reg        <= '0;
                base_reg     <= '0;
                ev_valid_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (ev_valid_reg)
                begin
                    run_reg <= blk_busy ? '0 : run_inc;
                end
                if (hit)
                begin
                    busy_reg     <= 1'b0;
                    found_reg    <= 1'b1;
                    slot_reg     <= slot_pos[SW-1:0];
                    ev_valid_reg <= 1'b0;
                end
                else if (miss)
                begin
                    busy_reg  <= 1'b0;
                    found_reg <= 1'b0;
                    slot_reg  <= '0;
                end
                else if (iss_end)
                begin
                    ev_valid_reg <= 1'b0;
                end
                else if (skip)
                begin
                    // region too short or finished: move to the next one
                    ev_valid_reg <= 1'b0;
                    base_reg     <= base_reg + POS_W'(len_cur);
                    r_reg        <= r_reg + RW'(1);
                    i_reg        <= '0;
                end
                else
                begin
                    ev_valid_reg <= 1'b1;
                    ev_first_reg <= (i_reg == '0);
                    ev_pos_reg   <= pos_cur;
                    ev_oob_reg   <= pos_cur >= POS_W'(TOTAL_BLOCKS);
                    i_reg        <= i_reg + LW'(1);
                end
            end
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.found = found_reg;
    assign rsp.slot  = slot_reg;

endmodule

[design/bitmap_first_fit_region_allocator.sv]
// top level of the bitmap first-fit region allocator
// depends on bffra_pkg, bffra_ram, bffra_div, bffra_scan and the assertion header
//
//  channel | signals                                   | direction
//  cfg     | cfg_we, cfg_index, cfg_data               | write only, no stall
//  in      | in_valid/in_ready: mode, message_bytes,   | request
//          |   block_index                             |
//  out     | out_valid/out_ready: status, slot_index   | one result per request
//
// a find first runs the serial divide of the size by the block size, then scans each
// searched region block by block, up to the sum of the region lengths (at most
// 4 x 2047) before out_valid; the single map read port paces the scan.
// a mark goes through the mark state and then the final state.
// one request is in flight at a time.
// after reset the map is cleared block by block before in_ready rises.
// a result that finds the output register still full waits for it to drain.
`include "bitmap_first_fit_region_allocator_assert.svh"
`timescale 1ns / 1ps

module bitmap_first_fit_region_allocator #(
    parameter int TOTAL_BLOCKS = 1024,
    parameter int MAX_REGIONS  = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bffra_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bffra_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bffra_pkg::MODE_W-1:0]        mode,
    input  logic [bffra_pkg::BYTES_W-1:0]       message_bytes,
    input  logic [bffra_pkg::IDX_W-1:0]         block_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bffra_pkg::STATUS_W-1:0]      status,
    output logic [bffra_pkg::SLOT_W-1:0]        slot_index
);

    localparam int MAP_AW = $clog2(TOTAL_BLOCKS);
    localparam int POS_W  = (MAP_AW + 1 > bffra_pkg::SPAN_W) ? MAP_AW + 1 : bffra_pkg::SPAN_W;
    localparam int LW     = bffra_pkg::LEN_W;
    localparam int RW     = bffra_pkg::REGN_W;
    localparam int BW     = bffra_pkg::BB_W;
    localparam int NW     = bffra_pkg::NUM_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_MARK,
        S_FIN
    } state_t;

    state_t state_reg;

    logic [BW-1:0] block_bytes_reg;
    logic [RW-1:0] regions_reg;
    logic [bffra_pkg::REGION_SLOTS-1:0][LW-1:0] region_len_reg;

    logic [MAP_AW-1:0] clr_reg;
    logic [bffra_pkg::MODE_W-1:0] mode_reg;
    logic [bffra_pkg::IDX_W-1:0]  idx_reg;
    logic [bffra_pkg::STATUS_W-1:0] res_status_reg;
    logic [bffra_pkg::SLOT_W-1:0]   res_slot_reg;
    logic                           out_valid_reg;
    logic [bffra_pkg::STATUS_W-1:0] status_reg;
    logic [bffra_pkg::SLOT_W-1:0]   slot_reg;

    bffra_pkg::div_req_t  div_req;
    bffra_pkg::div_rsp_t  div_rsp;
    bffra_pkg::scan_req_t scan_req;
    bffra_pkg::scan_rsp_t scan_rsp;

    logic              accept;
    logic [BW-1:0]     bb_eff;
    logic [RW-1:0]     nreg_eff;
    logic [POS_W-1:0]  idx_pos;
    logic              idx_in_map;
    logic              ram_we;
    logic [MAP_AW-1:0] ram_waddr;
    logic [0:0]        ram_wdata;
    logic [MAP_AW-1:0] ram_raddr;
    logic [0:0]        ram_rdata;
    logic              div_done;

    always_comb
    begin
        accept   = in_valid && in_ready;
        bb_eff   = (block_bytes_reg == '0) ? BW'(1) : block_bytes_reg;
        if (regions_reg == '0)
        begin
            nreg_eff = RW'(1);
        end
        else if (regions_reg > RW'(MAX_REGIONS))
        begin
            nreg_eff = RW'(MAX_REGIONS);
        end
        else
        begin
            nreg_eff = regions_reg;
        end

        div_req.start    = accept && (mode == bffra_pkg::MODE_FIND);
        div_req.dividend = NW'(message_bytes) + NW'(bb_eff) - NW'(1);
        div_req.divisor  = bb_eff;
        div_done         = div_rsp.done;

        scan_req.start = (state_reg == S_DIV) && div_done && (div_rsp.quot != '0);
        scan_req.need  = div_rsp.quot;
        scan_req.nreg  = nreg_eff;

        idx_pos    = POS_W'(idx_reg);
        idx_in_map = idx_pos < POS_W'(TOTAL_BLOCKS);

        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_MARK:
            begin
                ram_we    = idx_in_map && ((mode_reg == bffra_pkg::MODE_MARK_USED) ||
                                           (mode_reg == bffra_pkg::MODE_MARK_FREE));
                ram_waddr = idx_pos[MAP_AW-1:0];
                ram_wdata = (mode_reg == bffra_pkg::MODE_MARK_USED);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg   <= BW'(4096);
            regions_reg       <= RW'(1);
            region_len_reg[0] <= LW'(1024);
            region_len_reg[1] <= '0;
            region_len_reg[2] <= '0;
            region_len_reg[3] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bffra_pkg::CFG_BLOCK_BYTES: block_bytes_reg   <= cfg_data[BW-1:0];
                bffra_pkg::CFG_REGIONS:     regions_reg       <= cfg_data[RW-1:0];
                bffra_pkg::CFG_REGION0:     region_len_reg[0] <= cfg_data[LW-1:0];
                bffra_pkg::CFG_REGION1:     region_len_reg[1] <= cfg_data[LW-1:0];
                bffra_pkg::CFG_REGION2:     region_len_reg[2] <= cfg_data[LW-1:0];
                bffra_pkg::CFG_REGION3:     region_len_reg[3] <= cfg_data[LW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            mode_reg       <= '0;
            idx_reg        <= '0;
            res_status_reg <= '0;
            res_slot_reg   <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= '0;
            slot_reg       <= '0;
        end
        else
        begin
            // the final state refills the output register itself
            if (out_ready && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + MAP_AW'(1);
                    if (clr_reg == MAP_AW'(TOTAL_BLOCKS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg <= mode;
                        idx_reg  <= block_index;
                        state_reg <= (mode == bffra_pkg::MODE_FIND) ? S_DIV : S_MARK;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (div_rsp.quot == '0)
                        begin
                            // empty message lands at the start of region zero
                            res_status_reg <= bffra_pkg::ST_FOUND;
                            res_slot_reg   <= '0;
                            state_reg      <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (scan_rsp.done)
                    begin
                        res_status_reg <= scan_rsp.found ? bffra_pkg::ST_FOUND
                                                         : bffra_pkg::ST_NO_ROOM;
                        res_slot_reg   <= scan_rsp.found ? scan_rsp.slot : '0;
                        state_reg      <= S_FIN;
                    end
                end
                S_MARK:
                begin
                    res_status_reg <= bffra_pkg::ST_MARK_DONE;
                    res_slot_reg   <= '0;
                    state_reg      <= S_FIN;
                end
                S_FIN:
                begin
                    // hold the result until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= res_status_reg;
                        slot_reg      <= res_slot_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_index = slot_reg;

    bffra_ram #(
        .WIDTH (1),
        .DEPTH (TOTAL_BLOCKS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bffra_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    bffra_scan #(
        .TOTAL_BLOCKS (TOTAL_BLOCKS),
        .MAP_AW       (MAP_AW),
        .POS_W        (POS_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (scan_req),
        .region_len (region_len_reg),
        .rd_addr    (ram_raddr),
        .rd_data    (ram_rdata[0]),
        .rsp        (scan_rsp)
    );

    `BFFRA_ASSERT_NEVER(a_map_write_in_scan, (state_reg == S_SCAN) && ram_we)
    `BFFRA_ASSERT(a_div_done_in_div, div_done |-> (state_reg == S_DIV))
    `BFFRA_ASSERT(a_scan_done_in_scan, scan_rsp.done |-> (state_reg == S_SCAN))
    `BFFRA_ASSERT(a_slot_zero_unless_found, (out_valid && (status != bffra_pkg::ST_FOUND)) |-> (slot_index == '0))

endmodule

[sim/bitmap_first_fit_region_allocator_tb.sv]
// self-checking testbench for the bitmap first-fit region allocator
// depends on bffra_pkg and the bitmap_first_fit_region_allocator top level
`timescale 1ns / 1ps

module bitmap_first_fit_region_allocator_tb;

    localparam int MAP_BLOCKS       = 1024;
    localparam int MAX_REGION_COUNT = 4;
    localparam int DRAIN_CYCLES     = 16;
    localparam int MW               = bffra_pkg::MODE_W;
    localparam int YW               = bffra_pkg::BYTES_W;
    localparam int XW               = bffra_pkg::IDX_W;
    localparam int BW               = bffra_pkg::BB_W;
    localparam int RW               = bffra_pkg::REGN_W;
    localparam int LW               = bffra_pkg::LEN_W;
    localparam int DW               = bffra_pkg::CFG_DATA_W;
    localparam logic [MW-1:0] MODE_UNUSED = 2'd3;
    localparam logic [YW-1:0] BYTES_MAX   = 24'hFFFFFF;

    typedef struct packed {
        bffra_pkg::status_t          st;
        logic [bffra_pkg::SLOT_W-1:0] slot;
    } alloc_outcome_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_we = 1'b0;
    logic [bffra_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [DW-1:0]                      cfg_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [MW-1:0]                      mode = '0;
    logic [YW-1:0]                      message_bytes = '0;
    logic [XW-1:0]                      block_index = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [bffra_pkg::STATUS_W-1:0]     status;
    logic [bffra_pkg::SLOT_W-1:0]       slot_index;

    // shadow of the block state used for prediction
    bit                    occ_map [0:MAP_BLOCKS-1];
    logic [BW-1:0]         blk_bytes_cfg = 17'd4096;
    logic [RW-1:0]         regions_cfg = 3'd1;
    logic [LW-1:0]         region_len_cfg [0:MAX_REGION_COUNT-1] =
                               '{11'd1024, 11'd0, 11'd0, 11'd0};

    alloc_outcome_t        outcome_q [$];
    alloc_outcome_t        exp_outcome;
    int                    err_count = 0;
    bit                    steady = 1'b0;

    bitmap_first_fit_region_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .message_bytes (message_bytes),
        .block_index   (block_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .slot_index    (slot_index)
    );

    always #4 clk = ~clk;

    function automatic int unsigned active_regions();
        int unsigned nreg;
        nreg = regions_cfg;
        if (nreg == 0)
            nreg = 1;
        if (nreg > MAX_REGION_COUNT)
            nreg = MAX_REGION_COUNT;
        return nreg;
    endfunction

    // blocks covered by the searched regions, clipped to the map
    function automatic int unsigned mapped_span();
        int unsigned total, r;
        total = 0;
        for (r = 0; r < active_regions(); r++)
            total += region_len_cfg[r];
        if (total > MAP_BLOCKS)
            total = MAP_BLOCKS;
        if (total == 0)
            total = 1;
        return total;
    endfunction

    function automatic bit first_fit(input int unsigned need, output int unsigned slot);
        int unsigned nreg, base, run, len, r, i;
        slot = 0;
        nreg = active_regions();
        base = 0;
        for (r = 0; r < nreg; r++)
        begin
            len = region_len_cfg[r];
            if (need <= len)
            begin
                if (need == 0)
                begin
                    slot = base;
                    return 1'b1;
                end
                run = 0;
                for (i = 0; i < len; i++)
                begin
                    // blocks past the end of the map count as taken
                    if (base + i >= MAP_BLOCKS || occ_map[base + i])
                        run = 0;
                    else
                    begin
                        run++;
                        if (run == need)
                        begin
                            slot = base + i + 1 - need;
                            return 1'b1;
                        end
                    end
                end
            end
            base += len;
        end
        return 1'b0;
    endfunction

    function automatic alloc_outcome_t predict_outcome(input logic [MW-1:0] m,
                                                       input logic [YW-1:0] b,
                                                       input logic [XW-1:0] idx);
        alloc_outcome_t res;
        int unsigned bb, need, slot;
        res.st = bffra_pkg::ST_MARK_DONE;
        res.slot = '0;
        if (m == bffra_pkg::MODE_FIND)
        begin
            bb = (blk_bytes_cfg == 0) ? 1 : blk_bytes_cfg;
            need = (b + bb - 1) / bb;
            if (first_fit(need, slot))
            begin
                res.st = bffra_pkg::ST_FOUND;
                res.slot = slot[bffra_pkg::SLOT_W-1:0];
            end
            else
                res.st = bffra_pkg::ST_NO_ROOM;
        end
        else if (m == bffra_pkg::MODE_MARK_USED || m == bffra_pkg::MODE_MARK_FREE)
            occ_map[idx] = (m == bffra_pkg::MODE_MARK_USED);
        return res;
    endfunction

    // byte count that rounds up to exactly k blocks where the field allows it
    function automatic logic [YW-1:0] bytes_for_blocks(input int unsigned k);
        longint unsigned bb, lo, hi;
        bb = (blk_bytes_cfg == 0) ? 1 : blk_bytes_cfg;
        if (k == 0)
            return '0;
        lo = (k - 1) * bb + 1;
        hi = k * bb;
        if (lo > BYTES_MAX)
            return BYTES_MAX;
        if (hi > BYTES_MAX)
            hi = BYTES_MAX;
        return YW'($urandom_range(32'(hi), 32'(lo)));
    endfunction

    function automatic logic [YW-1:0] rand_bytes();
        return YW'($urandom_range(BYTES_MAX, 0));
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(input logic [MW-1:0] m, input logic [YW-1:0] b,
                                input logic [XW-1:0] idx, output alloc_outcome_t res);
        int unsigned gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        message_bytes <= b;
        block_index   <= idx;
        do @(posedge clk); while (!in_ready);
        res = predict_outcome(m, b, idx);
        outcome_q.push_back(res);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // writes every register, only called with nothing in flight
    task automatic load_config(input logic [BW-1:0] bb, input logic [RW-1:0] nreg,
                               input logic [LW-1:0] l0, input logic [LW-1:0] l1,
                               input logic [LW-1:0] l2, input logic [LW-1:0] l3);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= bffra_pkg::CFG_BLOCK_BYTES;
        cfg_data  <= bb;
        @(negedge clk);
        cfg_index <= bffra_pkg::CFG_REGIONS;
        cfg_data  <= DW'(nreg);
        @(negedge clk);
        cfg_index <= bffra_pkg::CFG_REGION0;
        cfg_data  <= DW'(l0);
        @(negedge clk);
        cfg_index <= bffra_pkg::CFG_REGION1;
        cfg_data  <= DW'(l1);
        @(negedge clk);
        cfg_index <= bffra_pkg::CFG_REGION2;
        cfg_data  <= DW'(l2);
        @(negedge clk);
        cfg_index <= bffra_pkg::CFG_REGION3;
        cfg_data  <= DW'(l3);
        @(negedge clk);
        cfg_we <= 1'b0;
        blk_bytes_cfg     = bb;
        regions_cfg       = nreg;
        region_len_cfg[0] = l0;
        region_len_cfg[1] = l1;
        region_len_cfg[2] = l2;
        region_len_cfg[3] = l3;
    endtask

    task automatic random_config(input bit big);
        logic [BW-1:0]   bb;
        logic [RW-1:0]   nreg;
        logic [LW-1:0]   lens [0:MAX_REGION_COUNT-1];
        int unsigned     r;
        case ($urandom_range(0, 5))
            0:       bb = '0;
            1:       bb = 17'd1;
            2:       bb = 17'h10000;
            3:       bb = 17'd1 << $urandom_range(0, 15);
            default: bb = BW'($urandom_range(1, 65536));
        endcase
        if ($urandom_range(0, 99) < 80)
            nreg = RW'($urandom_range(1, 4));
        else
            nreg = RW'($urandom_range(0, 7));
        for (r = 0; r < MAX_REGION_COUNT; r++)
        begin
            if (!big)
                lens[r] = LW'($urandom_range(0, 40));
            else if ($urandom_range(0, 9) == 0)
                lens[r] = 11'd2047;
            else
                lens[r] = LW'($urandom_range(64, 600));
        end
        load_config(bb, nreg, lens[0], lens[1], lens[2], lens[3]);
    endtask

    task automatic test_default_config();
        alloc_outcome_t res;
        send_request(bffra_pkg::MODE_FIND, 24'd0, 10'd0, res);
        send_request(bffra_pkg::MODE_FIND, 24'd1, 10'd0, res);
        send_request(bffra_pkg::MODE_MARK_USED, 24'd0, 10'd0, res);
        send_request(bffra_pkg::MODE_MARK_USED, BYTES_MAX, 10'd2, res);
        send_request(bffra_pkg::MODE_FIND, 24'd4096, 10'd0, res);
        send_request(bffra_pkg::MODE_FIND, 24'd4097, 10'd1023, res);
        send_request(bffra_pkg::MODE_MARK_FREE, 24'd0, 10'd0, res);
        send_request(bffra_pkg::MODE_FIND, 24'd8192, 10'd0, res);
        send_request(bffra_pkg::MODE_MARK_USED, 24'd0, 10'd1023, res);
        send_request(bffra_pkg::MODE_FIND, BYTES_MAX, 10'd0, res);
        send_request(MODE_UNUSED, BYTES_MAX, 10'd5, res);
        send_request(bffra_pkg::MODE_MARK_FREE, 24'd0, 10'd2, res);
        send_request(bffra_pkg::MODE_MARK_FREE, 24'd0, 10'd1023, res);
    endtask

    task automatic test_config_corners();
        alloc_outcome_t res;
        // zero block size acts as one byte, zero region count as one region
        drain_results();
        load_config('0, 3'd0, 11'd16, 11'd5, 11'd9, 11'd2047);
        send_request(bffra_pkg::MODE_FIND, 24'd16, 10'd0, res);
        send_request(bffra_pkg::MODE_FIND, 24'd17, 10'd0, res);
        send_request(bffra_pkg::MODE_FIND, 24'd0, 10'd0, res);
        // count above four is clipped, last region runs off the end of the map
        drain_results();
        load_config(17'h10000, 3'd7, 11'd0, 11'd8, 11'd0, 11'd2047);
        send_request(bffra_pkg::MODE_FIND, 24'd524288, 10'd0, res);
        send_request(bffra_pkg::MODE_FIND, 24'd524289, 10'd0, res);
        send_request(bffra_pkg::MODE_FIND, BYTES_MAX, 10'd0, res);
        drain_results();
        load_config(17'd1, 3'd4, 11'd1000, 11'd1000, 11'd0, 11'd0);
        send_request(bffra_pkg::MODE_FIND, 24'd1001, 10'd0, res);
        send_request(bffra_pkg::MODE_FIND, 24'd1000, 10'd0, res);
    endtask

    task automatic run_random_phase(input int n_items);
        alloc_outcome_t grant, res;
        int unsigned    done_items, r, span, k, start, cnt, i;
        logic [MW-1:0]  m;
        done_items = 0;
        span = mapped_span();
        while (done_items < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                // allocate a run, then claim up to eight of the blocks it returned
                if (r < 4)
                    k = 0;
                else if ($urandom_range(0, 3) == 0)
                    k = $urandom_range(1, span);
                else
                    k = $urandom_range(1, 6);
                send_request(bffra_pkg::MODE_FIND, bytes_for_blocks(k),
                             XW'($urandom_range(0, 1023)), grant);
                done_items++;
                if (grant.st == bffra_pkg::ST_FOUND)
                    for (i = 0; i < k && i < 8; i++)
                    begin
                        send_request(bffra_pkg::MODE_MARK_USED, rand_bytes(),
                                     XW'(grant.slot + i), res);
                        done_items++;
                    end
            end
            else if (r < 65)
            begin
                start = $urandom_range(0, span - 1);
                cnt = $urandom_range(1, 4);
                for (i = 0; i < cnt && start + i < MAP_BLOCKS; i++)
                begin
                    send_request(bffra_pkg::MODE_MARK_FREE, rand_bytes(),
                                 XW'(start + i), res);
                    done_items++;
                end
            end
            else if (r < 80)
            begin
                send_request(bffra_pkg::MODE_FIND,
                             bytes_for_blocks($urandom_range(1, span + 4)),
                             XW'($urandom_range(0, 1023)), res);
                done_items++;
            end
            else if (r < 92)
            begin
                m = $urandom_range(0, 1) ? bffra_pkg::MODE_MARK_USED
                                         : bffra_pkg::MODE_MARK_FREE;
                send_request(m, rand_bytes(), XW'($urandom_range(0, span - 1)), res);
                done_items++;
            end
            else
            begin
                m = MW'($urandom_range(0, 3));
                send_request(m, rand_bytes(), XW'($urandom_range(0, 1023)), res);
                if (m != MODE_UNUSED)
                    done_items++;
            end
        end
    endtask

    task automatic test_random_traffic();
        int p;
        for (p = 0; p < 12; p++)
        begin
            drain_results();
            random_config(p % 4 == 2);
            steady = (p == 5);
            if (p == 7)
            begin
                run_random_phase(22);
                // hold the sender until the block has answered everything
                drain_results();
                run_random_phase(22);
            end
            else
                run_random_phase(44);
        end
        steady = 1'b0;
    endtask

    // result side: random stalls with occasional long holds, always ready when steady
    initial
    begin : ready_driver
        int unsigned r, len;
        logic lvl;
        forever
        begin
            r = $urandom_range(0, 99);
            if (steady)
            begin
                lvl = 1'b1;
                len = 1;
            end
            else if (r < 65)
            begin
                lvl = 1'b1;
                len = $urandom_range(1, 6);
            end
            else if (r < 95)
            begin
                lvl = 1'b0;
                len = $urandom_range(1, 3);
            end
            else
            begin
                lvl = 1'b0;
                len = $urandom_range(20, 80);
            end
            repeat (len)
            begin
                @(negedge clk);
                out_ready <= lvl;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (outcome_q.size() == 0)
            begin
                if (err_count < 10)
                    $display("unexpected result: status %0d slot %0d", status, slot_index);
                err_count++;
            end
            else
            begin
                exp_outcome = outcome_q.pop_front();
                if (status !== exp_outcome.st || slot_index !== exp_outcome.slot)
                begin
                    if (err_count < 10)
                        $display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                                 exp_outcome.st, exp_outcome.slot, status, slot_index);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        #200_000_000;
        $display("bitmap_first_fit_region_allocator regression: fail");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < MAP_BLOCKS; i++)
            occ_map[i] = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_config();
        test_config_corners();
        test_random_traffic();

        drain_results();
        repeat (64) @(posedge clk);
        if (err_count == 0 && outcome_q.size() == 0)
            $display("bitmap_first_fit_region_allocator regression: pass");
        else
            $display("bitmap_first_fit_region_allocator regression: fail");
        $finish;
    end

endmodule
